[rtl/core/arvd_pkg.sv]
package arvd_pkg;

  localparam logic [31:0] BottomVal = 32'h0080_0000;
  localparam logic [31:0] SeedRange = 32'd128;
  localparam logic [3:0]  MaxOut    = 4'd8;
  localparam logic [4:0]  KReset    = 5'd10;
  localparam logic [31:0] SumReset  = 32'd16384;

  localparam logic [3:0] PhSkip  = 4'd0;
  localparam logic [3:0] PhSeed  = 4'd1;
  localparam logic [3:0] PhSym   = 4'd2;
  localparam logic [3:0] PhEscHi = 4'd3;
  localparam logic [3:0] PhEscLo = 4'd4;
  localparam logic [3:0] PhBase  = 4'd5;
  localparam logic [3:0] PhBaseA = 4'd6;
  localparam logic [3:0] PhBaseB = 4'd7;

  // Cumulative frequency of overflow symbols, index 0..64.
  function automatic logic [16:0] cum_f(input logic [6:0] idx);
    logic [16:0] r;
    case (idx)
      7'd0:    r = 17'd0;
      7'd1:    r = 17'd19578;
      7'd2:    r = 17'd36160;
      7'd3:    r = 17'd48417;
      7'd4:    r = 17'd56323;
      7'd5:    r = 17'd60899;
      7'd6:    r = 17'd63265;
      7'd7:    r = 17'd64435;
      7'd8:    r = 17'd64971;
      7'd9:    r = 17'd65232;
      7'd10:   r = 17'd65351;
      7'd11:   r = 17'd65416;
      7'd12:   r = 17'd65447;
      7'd13:   r = 17'd65466;
      7'd14:   r = 17'd65476;
      7'd15:   r = 17'd65482;
      7'd16:   r = 17'd65485;
      7'd17:   r = 17'd65488;
      default: r = 17'd65472 + {10'd0, idx};
    endcase
    return r;
  endfunction

  function automatic logic [14:0] wid_f(input logic [5:0] idx);
    logic [14:0] r;
    case (idx)
      6'd0:    r = 15'd19578;
      6'd1:    r = 15'd16582;
      6'd2:    r = 15'd12257;
      6'd3:    r = 15'd7906;
      6'd4:    r = 15'd4576;
      6'd5:    r = 15'd2366;
      6'd6:    r = 15'd1170;
      6'd7:    r = 15'd536;
      6'd8:    r = 15'd261;
      6'd9:    r = 15'd119;
      6'd10:   r = 15'd65;
      6'd11:   r = 15'd31;
      6'd12:   r = 15'd19;
      6'd13:   r = 15'd10;
      6'd14:   r = 15'd6;
      6'd15:   r = 15'd3;
      6'd16:   r = 15'd3;
      6'd17:   r = 15'd2;
      default: r = 15'd1;
    endcase
    return r;
  endfunction

  // Adaptation boundaries for k; entry 0 and entries 28 and above are zero.
  function automatic logic [31:0] kbound_f(input logic [5:0] k);
    logic [31:0] r;
    if (k == 6'd0 || k > 6'd27) begin
      r = 32'd0;
    end else begin
      r = 32'd1 << (k + 6'd4);
    end
    return r;
  endfunction

endpackage

[rtl/core/adaptive_range_value_decoder.sv]
// Adaptive range value decoder.
// Compressed bytes enter on the s_axis channel, decoded values leave on the
// m_axis channel with tlast set on the last value produced by a byte. A byte
// may produce no value or several. The cfg channel writes signed_mode, which
// selects zigzag-to-signed conversion; write it only while the block is idle.
// After reset the first byte is skipped and the second seeds the coder.
// A byte is accepted only while the sequencer is idle. Each value costs three
// to six passes through the shared restoring divider (three for a single
// base, four for a split base, two more after an escape), a sequential
// symbol table search and the multiply and update states; a byte that yields
// values ends with a flush state, and skip and seed bytes are taken in idle.
// Values are held one deep inside so tlast can be attached; a stalled receiver
// holds the sequencer in its emit or flush state until the output register
// frees up. Reset clears low and buffer, range = 128, k = 10, running sum = 16384.
module adaptive_range_value_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] decoded_value
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDisp   = 4'd1;
  localparam logic [3:0] SShift  = 4'd2;
  localparam logic [3:0] SDiv    = 4'd3;
  localparam logic [3:0] SRDiv   = 4'd4;
  localparam logic [3:0] SQDiv   = 4'd5;
  localparam logic [3:0] SLowSub = 4'd6;
  localparam logic [3:0] SSymQ   = 4'd7;
  localparam logic [3:0] SSearch = 4'd8;
  localparam logic [3:0] SSymM1  = 4'd9;
  localparam logic [3:0] SSymM2  = 4'd10;
  localparam logic [3:0] SFinMul = 4'd11;
  localparam logic [3:0] SFinV   = 4'd12;
  localparam logic [3:0] SFinK   = 4'd13;
  localparam logic [3:0] SEmit   = 4'd14;
  localparam logic [3:0] SFlush  = 4'd15;

  logic [3:0]  state_q;
  logic [3:0]  phase_q;
  logic [31:0] low_q, range_q, buf_q, sum_q, ovf_q, basep_q;
  logic [4:0]  k_q;
  logic        signed_q;
  logic [3:0]  n_q;
  logic [31:0] q_q, prod_q, v_q, base_q, tmp_q;
  logic [3:0]  sh_q;
  logic [5:0]  sym_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q, den_q;
  logic [4:0]  cnt_q;
  logic [3:0]  ret_q;
  logic        pend_q;
  logic [31:0] pend_data_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  logic        in_acc, out_free, sign_ok, out_load;
  logic [31:0] pivot, val_w;
  logic [32:0] rem_sh;
  logic [31:0] sum_new;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (((state_q == SEmit) && pend_q) || (state_q == SFlush)) && out_free;

  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign pivot  = (sum_q[31:5] == 27'd0) ? 32'd1 : {5'd0, sum_q[31:5]};
  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign sign_ok = rem_sh >= {1'b0, den_q};
  assign val_w  = !signed_q ? v_q :
                  (v_q[0] ? ({1'b0, v_q[31:1]} + 32'd1) : (32'd0 - {1'b0, v_q[31:1]}));
  // The rounded half wraps with the value, so all ones adds nothing.
  assign sum_new = sum_q + ((v_q + 32'd1) >> 1) - ((sum_q + 32'd16) >> 5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= arvd_pkg::PhSkip;
      low_q       <= 32'd0;
      range_q     <= arvd_pkg::SeedRange;
      buf_q       <= 32'd0;
      sum_q       <= arvd_pkg::SumReset;
      k_q         <= arvd_pkg::KReset;
      ovf_q       <= 32'd0;
      basep_q     <= 32'd0;
      signed_q    <= 1'b0;
      n_q         <= 4'd0;
      cnt_q       <= 5'd0;
      ret_q       <= SIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        signed_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            if (phase_q == arvd_pkg::PhSkip) begin
              phase_q <= arvd_pkg::PhSeed;
            end else if (phase_q == arvd_pkg::PhSeed) begin
              buf_q   <= {24'd0, s_axis_tdata};
              low_q   <= {25'd0, s_axis_tdata[7:1]};
              range_q <= arvd_pkg::SeedRange;
              phase_q <= arvd_pkg::PhSym;
            end else begin
              if (range_q <= arvd_pkg::BottomVal) begin
                buf_q   <= {buf_q[23:0], s_axis_tdata};
                low_q   <= {low_q[23:0], buf_q[0], s_axis_tdata[7:1]};
                range_q <= {range_q[23:0], 8'd0};
              end
              n_q     <= 4'd0;
              state_q <= SDisp;
            end
          end
        end
        SDisp: begin
          if (range_q > arvd_pkg::BottomVal && n_q < arvd_pkg::MaxOut) begin
            rem_q <= 33'd0;
            cnt_q <= 5'd0;
            case (phase_q)
              arvd_pkg::PhEscHi, arvd_pkg::PhEscLo: begin
                range_q <= range_q >> 16;
                quo_q   <= low_q;
                den_q   <= range_q >> 16;
                ret_q   <= SQDiv;
                state_q <= SDiv;
              end
              arvd_pkg::PhBase: begin
                quo_q   <= range_q;
                den_q   <= pivot;
                ret_q   <= SRDiv;
                state_q <= SDiv;
              end
              arvd_pkg::PhBaseA, arvd_pkg::PhBaseB: begin
                tmp_q   <= pivot;
                sh_q    <= 4'd0;
                state_q <= SShift;
              end
              default: begin
                range_q <= range_q >> 16;
                quo_q   <= low_q;
                den_q   <= range_q >> 16;
                ret_q   <= SSymQ;
                state_q <= SDiv;
              end
            endcase
          end else if (pend_q) begin
            state_q <= SFlush;
          end else begin
            state_q <= SIdle;
          end
        end
        SShift: begin
          // Halve the pivot until it fits in 16 bits; the count is the split shift.
          if (tmp_q >= 32'd65536) begin
            tmp_q <= tmp_q >> 1;
            sh_q  <= sh_q + 4'd1;
          end else if (phase_q == arvd_pkg::PhBaseA) begin
            quo_q   <= range_q;
            den_q   <= tmp_q + 32'd1;
            ret_q   <= SRDiv;
            state_q <= SDiv;
          end else begin
            range_q <= range_q >> sh_q;
            quo_q   <= low_q;
            den_q   <= range_q >> sh_q;
            ret_q   <= SQDiv;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (sign_ok) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= ret_q;
          end
        end
        SRDiv: begin
          range_q <= quo_q;
          den_q   <= quo_q;
          quo_q   <= low_q;
          rem_q   <= 33'd0;
          cnt_q   <= 5'd0;
          ret_q   <= SQDiv;
          state_q <= SDiv;
        end
        SQDiv: begin
          q_q     <= quo_q;
          prod_q  <= range_q * quo_q;
          state_q <= SLowSub;
        end
        SLowSub: begin
          low_q   <= low_q - prod_q;
          state_q <= SDisp;
          case (phase_q)
            arvd_pkg::PhEscHi: begin
              ovf_q   <= {q_q[15:0], 16'd0};
              phase_q <= arvd_pkg::PhEscLo;
            end
            arvd_pkg::PhEscLo: begin
              ovf_q   <= ovf_q | q_q;
              phase_q <= (pivot >= 32'd65536) ? arvd_pkg::PhBaseA : arvd_pkg::PhBase;
            end
            arvd_pkg::PhBaseA: begin
              basep_q <= q_q;
              phase_q <= arvd_pkg::PhBaseB;
            end
            arvd_pkg::PhBaseB: begin
              base_q  <= (basep_q << sh_q) + q_q;
              state_q <= SFinMul;
            end
            default: begin
              base_q  <= q_q;
              state_q <= SFinMul;
            end
          endcase
        end
        SSymQ: begin
          q_q     <= quo_q;
          sym_q   <= 6'd0;
          state_q <= SSearch;
        end
        SSearch: begin
          if (sym_q != 6'd63 && q_q >= {15'd0, arvd_pkg::cum_f({1'b0, sym_q} + 7'd1)}) begin
            sym_q <= sym_q + 6'd1;
          end else begin
            state_q <= SSymM1;
          end
        end
        SSymM1: begin
          prod_q  <= range_q * {15'd0, arvd_pkg::cum_f({1'b0, sym_q})};
          state_q <= SSymM2;
        end
        SSymM2: begin
          low_q   <= low_q - prod_q;
          range_q <= range_q * {17'd0, arvd_pkg::wid_f(sym_q)};
          if (sym_q == 6'd63) begin
            phase_q <= arvd_pkg::PhEscHi;
          end else begin
            ovf_q   <= {26'd0, sym_q};
            phase_q <= (pivot >= 32'd65536) ? arvd_pkg::PhBaseA : arvd_pkg::PhBase;
          end
          state_q <= SDisp;
        end
        SFinMul: begin
          prod_q  <= ovf_q * pivot;
          state_q <= SFinV;
        end
        SFinV: begin
          v_q     <= base_q + prod_q;
          state_q <= SFinK;
        end
        SFinK: begin
          sum_q <= sum_new;
          if (sum_new < arvd_pkg::kbound_f({1'b0, k_q})) begin
            if (k_q != 5'd0) begin
              k_q <= k_q - 5'd1;
            end
          end else if (sum_new >= arvd_pkg::kbound_f({1'b0, k_q} + 6'd1)) begin
            if (k_q != 5'd31) begin
              k_q <= k_q + 5'd1;
            end
          end
          phase_q <= arvd_pkg::PhSym;
          state_q <= SEmit;
        end
        SEmit: begin
          // The previous value leaves only once it is known not to be the last.
          if (!pend_q) begin
            pend_q      <= 1'b1;
            pend_data_q <= val_w;
            n_q         <= n_q + 4'd1;
            state_q     <= SDisp;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= pend_data_q;
            out_last_q  <= 1'b0;
            pend_data_q <= val_w;
            n_q         <= n_q + 4'd1;
            state_q     <= SDisp;
          end
        end
        SFlush: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= pend_data_q;
            out_last_q  <= 1'b1;
            pend_q      <= 1'b0;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SIdle |-> !pend_q)
    else $error("value left pending while idle");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= arvd_pkg::MaxOut)
    else $error("too many values for one byte");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFlush && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("flush did not mark last value");

endmodule

[tb/adaptive_range_value_decoder_tb.sv]
module adaptive_range_value_decoder_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  adaptive_range_value_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } value_t;

  value_t      value_q[$];
  int unsigned error_count;
  int unsigned hold_cycles;
  bit          stall_on;

  // Decoder state mirror.
  bit          sgn_mode;
  logic [31:0] low_r, range_r, buf_r, sum_r, ovf_r, basep_r;
  logic [4:0]  k_r;
  logic [3:0]  phase_r;

  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = 1'b1;
      #6 clk_i = 1'b0;
    end
  end

  function automatic logic [31:0] cum_at(int i);
    int unsigned t[18] = '{0, 19578, 36160, 48417, 56323, 60899, 63265, 64435, 64971,
                           65232, 65351, 65416, 65447, 65466, 65476, 65482, 65485, 65488};
    if (i < 18) return t[i];
    return 32'd65472 + i;
  endfunction

  function automatic logic [31:0] bound_at(int k);
    if (k == 0 || k > 27) return 32'd0;
    return 32'd1 << (k + 4);
  endfunction

  function automatic logic [31:0] qdiv(logic [31:0] a, logic [31:0] b);
    return (b == 0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  function automatic logic [31:0] pivot();
    logic [31:0] p;
    p = sum_r / 32;
    return (p == 0) ? 32'd1 : p;
  endfunction

  function automatic logic [31:0] split_div(logic [31:0] p);
    int bits;
    bits = 0;
    while (bits < 32 && (p >> bits) != 0) bits++;
    return (bits > 16) ? (32'd1 << (bits - 16)) : 32'd1;
  endfunction

  function automatic logic [3:0] base_ph();
    return (pivot() >= 32'd65536) ? arvd_pkg::PhBaseA : arvd_pkg::PhBase;
  endfunction

  function automatic logic [31:0] narrow(logic [31:0] d);
    logic [31:0] q;
    range_r = qdiv(range_r, d);
    q = qdiv(low_r, range_r);
    low_r = low_r - range_r * q;
    return q;
  endfunction

  function automatic logic [31:0] close_value(logic [31:0] base);
    logic [31:0] v;
    v = base + ovf_r * pivot();
    sum_r = sum_r + ((v + 32'd1) / 2) - ((sum_r + 32'd16) >> 5);
    if (sum_r < bound_at(int'(k_r))) begin
      if (k_r > 0) k_r--;
    end else if (sum_r >= bound_at(int'(k_r) + 1)) begin
      if (k_r < 31) k_r++;
    end
    phase_r = arvd_pkg::PhSym;
    if (sgn_mode) return v[0] ? (v >> 1) + 32'd1 : 32'd0 - (v >> 1);
    return v;
  endfunction

  task automatic predict_byte(logic [7:0] b);
    int n;
    int sym;
    logic [31:0] q, v;
    bit done;
    n = 0;
    if (phase_r == arvd_pkg::PhSkip) begin
      phase_r = arvd_pkg::PhSeed;
      return;
    end
    if (phase_r == arvd_pkg::PhSeed) begin
      buf_r = b;
      low_r = b >> 1;
      range_r = arvd_pkg::SeedRange;
      phase_r = arvd_pkg::PhSym;
      return;
    end
    if (range_r <= arvd_pkg::BottomVal) begin
      buf_r = (buf_r << 8) | b;
      low_r = (low_r << 8) | ((buf_r >> 1) & 32'hFF);
      range_r = range_r << 8;
    end
    while (range_r > arvd_pkg::BottomVal && n < arvd_pkg::MaxOut) begin
      done = 0;
      case (phase_r)
        arvd_pkg::PhEscHi: begin
          ovf_r = narrow(32'd65536) << 16;
          phase_r = arvd_pkg::PhEscLo;
        end
        arvd_pkg::PhEscLo: begin
          ovf_r = ovf_r | narrow(32'd65536);
          phase_r = base_ph();
        end
        arvd_pkg::PhBase: begin
          v = close_value(narrow(pivot()));
          done = 1;
        end
        arvd_pkg::PhBaseA: begin
          basep_r = narrow(pivot() / split_div(pivot()) + 32'd1);
          phase_r = arvd_pkg::PhBaseB;
        end
        arvd_pkg::PhBaseB: begin
          q = narrow(split_div(pivot()));
          v = close_value(basep_r * split_div(pivot()) + q);
          done = 1;
        end
        default: begin
          sym = 0;
          range_r = range_r >> 16;
          q = qdiv(low_r, range_r);
          while (sym < 63 && q >= cum_at(sym + 1)) sym++;
          low_r = low_r - range_r * cum_at(sym);
          range_r = range_r * ((sym < 63) ? cum_at(sym + 1) - cum_at(sym) : 32'd1);
          if (sym == 63) begin
            phase_r = arvd_pkg::PhEscHi;
          end else begin
            ovf_r = sym;
            phase_r = base_ph();
          end
        end
      endcase
      if (done) begin
        value_q.push_back('{value: v, last: 1'b0});
        n++;
      end
    end
    if (n > 0) value_q[value_q.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  // Receiver: random stall pattern, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (stall_on) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (value_q.size() == 0) begin
        report("unexpected value", m_axis_tdata, 32'd0);
      end else begin
        if (m_axis_tdata !== value_q[0].value) report("value", m_axis_tdata, value_q[0].value);
        if (m_axis_tlast !== value_q[0].last) begin
          report("tlast", {31'd0, m_axis_tlast}, {31'd0, value_q[0].last});
        end
        void'(value_q.pop_front());
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      repeat ($urandom_range(1, 8)) begin
        if (left > 0) begin
          send_byte(8'($urandom_range(0, 255)));
          left--;
        end
      end
      repeat ($urandom_range(0, 40)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (value_q.size() != 0) @(negedge clk_i);
    // A byte may yield nothing while the sequencer is still busy.
    repeat (2000) @(negedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    sgn_mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [7:0] pat[12] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
                            8'h01, 8'hFE, 8'hFF, 8'hFF};
    foreach (pat[i]) send_byte(pat[i]);
    // All-ones bytes drive the quotient to the table end and the escape.
    repeat (8) send_byte(8'hFF);
    repeat (4) send_byte(8'h00);
    drain();
  endtask

  task automatic test_unsigned_random();
    write_mode(1'b0);
    send_burst(90);
    drain();
  endtask

  task automatic test_signed_random();
    write_mode(1'b1);
    send_burst(90);
    drain();
  endtask

  task automatic test_backpressure();
    write_mode(1'b1);
    hold_cycles = 3000;
    send_burst(30);
    drain();
    write_mode(1'b0);
    send_burst(50);
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    error_count   = 0;
    hold_cycles   = 0;
    stall_on      = 1'b0;
    sgn_mode      = 1'b0;
    low_r = 0; range_r = arvd_pkg::SeedRange; buf_r = 0; sum_r = arvd_pkg::SumReset;
    ovf_r = 0; basep_r = 0; k_r = arvd_pkg::KReset; phase_r = arvd_pkg::PhSkip;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    stall_on = 1'b1;
    test_unsigned_random();
    test_signed_random();
    stall_on = 1'b0;
    test_unsigned_random();
    stall_on = 1'b1;
    test_backpressure();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/arvd_pkg.sv
rtl/core/adaptive_range_value_decoder.sv
tb/adaptive_range_value_decoder_tb.sv
